/* hw/rtl/scdp_pkg.sv */
// shared types and constants for the sparse column dot product block
package scdp_pkg;

  localparam int VECTOR_DEPTH_DEF = 4096;
  localparam int MAX_COLUMNS_DEF  = 65536;
  localparam int QUEUE_DEPTH      = 4;
  localparam int INDEX_W          = 12;
  localparam int VALUE_W          = 32;
  localparam int COLUMN_W         = 16;
  localparam int ACC_W            = 64;
  localparam int FRAC_W           = 16;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_ENTRY = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  typedef struct packed {
    logic [1:0]                 operation;
    logic [INDEX_W-1:0]         index;
    logic signed [VALUE_W-1:0]  value;
    logic                       last;
  } item_t;

  typedef struct packed {
    logic [COLUMN_W-1:0]        column_number;
    logic signed [VALUE_W-1:0]  dot_result;
    logic                       saturated;
  } result_t;

  typedef struct packed {
    logic [1:0]                 op;
    logic                       hit;
    logic                       emit;
    logic [INDEX_W-1:0]         index;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

endpackage

/* hw/rtl/scdp_front.sv */
// front stage: accepts input words, classifies them and hands commands to the queue
module scdp_front #(
  parameter int VECTOR_DEPTH = scdp_pkg::VECTOR_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  scdp_pkg::item_t in_word_i,
  output logic           cmd_valid_o,
  input  logic           cmd_full_i,
  output scdp_pkg::cmd_t cmd_o
);
  import scdp_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic accept, push, useful;

  assign in_stall_o  = valid_q && cmd_full_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign push        = valid_q && !cmd_full_i;
  assign cmd_valid_o = push;
  assign cmd_o       = cmd_q;

  always_comb begin
    useful = 1'b0;
    cmd_d  = cmd_q;
    unique case (in_word_i.operation)
      OP_WRITE: useful = 1'b1;
      OP_ENTRY: useful = 1'b1;
      OP_CLOSE: useful = 1'b1;
      default:  useful = 1'b0;
    endcase
    if (accept) begin
      cmd_d.op    = in_word_i.operation;
      cmd_d.hit   = {{(17 - INDEX_W){1'b0}}, in_word_i.index} < 17'(VECTOR_DEPTH);
      cmd_d.emit  = (in_word_i.operation == OP_CLOSE) ||
                    ((in_word_i.operation == OP_ENTRY) && in_word_i.last);
      cmd_d.index = in_word_i.index;
      cmd_d.value = in_word_i.value;
    end
    if (accept) begin
      valid_d = useful;
    end else if (push) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

/* hw/rtl/scdp_queue.sv */
// short command queue between the front and back stages
module scdp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  scdp_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output scdp_pkg::cmd_t pop_cmd_o
);
  import scdp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  cmd_t             slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o    = count_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o   = count_q != '0;
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;
  assign pop_cmd_o = slots_q[rd_q];

  always_comb begin
    wr_d    = do_push ? wr_q + 1'b1 : wr_q;
    rd_d    = do_pop ? rd_q + 1'b1 : rd_q;
    count_d = count_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= push_cmd_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1 && count_q <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue count out of step");
`endif

endmodule

/* hw/rtl/scdp_back.sv */
// back stages: dense store access, multiply, saturating accumulate and output conversion
module scdp_back #(
  parameter int VECTOR_DEPTH = scdp_pkg::VECTOR_DEPTH_DEF,
  parameter int MAX_COLUMNS  = scdp_pkg::MAX_COLUMNS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  scdp_pkg::cmd_t   cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output scdp_pkg::result_t out_word_o
);
  import scdp_pkg::*;

  localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam int Q_W = ACC_W - FRAC_W;

  logic adv;
  logic [AW-1:0] addr;

  logic [VALUE_W-1:0] dense_q [VECTOR_DEPTH];
  logic [VALUE_W-1:0] rdata_q;

  logic                      s1_valid_q, s1_entry_q, s1_hit_q, s1_emit_q;
  logic signed [VALUE_W-1:0] s1_value_q;

  logic                      s2_valid_q, s2_emit_q;
  logic signed [ACC_W-1:0]   prod_q;

  logic signed [ACC_W-1:0]   acc_q;
  logic                      ovf_q;
  logic [COLUMN_W-1:0]       col_q, col_d;

  logic                      s3_valid_q, s3_sat_q;
  logic signed [ACC_W-1:0]   s3_sum_q;
  logic [COLUMN_W-1:0]       s3_col_q;

  logic                      out_valid_q;
  result_t                   out_q;

  logic signed [ACC_W:0]     wide;
  logic                      add_ovf;
  logic signed [ACC_W-1:0]   sum;
  logic signed [Q_W-1:0]     q_val;
  logic                      q_fits;

  assign adv         = !out_valid_q || !out_stall_i;
  assign cmd_pop_o   = adv && cmd_valid_i;
  assign addr        = AW'(cmd_i.index);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // store access
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.hit) begin
      if (cmd_i.op == OP_WRITE) begin
        dense_q[addr] <= cmd_i.value;
      end
      if (cmd_i.op == OP_ENTRY) begin
        rdata_q <= dense_q[addr];
      end
    end
  end

  // saturating accumulate
  always_comb begin
    wide    = {acc_q[ACC_W-1], acc_q} + {prod_q[ACC_W-1], prod_q};
    add_ovf = wide[ACC_W] != wide[ACC_W-1];
    if (add_ovf) begin
      sum = wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum = wide[ACC_W-1:0];
    end
    col_d  = (col_q == COLUMN_W'(MAX_COLUMNS - 1)) ? '0 : col_q + 1'b1;
    q_val  = s3_sum_q[ACC_W-1:FRAC_W];
    q_fits = (&q_val[Q_W-1:VALUE_W-1]) || !(|q_val[Q_W-1:VALUE_W-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      col_q       <= '0;
    end else if (adv) begin
      s1_valid_q  <= cmd_valid_i && (cmd_i.op == OP_ENTRY || cmd_i.op == OP_CLOSE);
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q && s2_emit_q;
      out_valid_q <= s3_valid_q;
      if (s2_valid_q) begin
        if (s2_emit_q) begin
          acc_q <= '0;
          ovf_q <= 1'b0;
          col_q <= col_d;
        end else begin
          acc_q <= sum;
          ovf_q <= ovf_q || add_ovf;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_entry_q <= cmd_i.op == OP_ENTRY;
      s1_hit_q   <= cmd_i.hit;
      s1_emit_q  <= cmd_i.emit;
      s1_value_q <= cmd_i.value;
      s2_emit_q  <= s1_emit_q;
      if (s1_entry_q && s1_hit_q) begin
        prod_q <= $signed(rdata_q) * s1_value_q;
      end else begin
        prod_q <= '0;
      end
      s3_sum_q <= sum;
      s3_sat_q <= ovf_q || add_ovf;
      s3_col_q <= col_q;
      out_q.column_number <= s3_col_q;
      out_q.saturated     <= s3_sat_q || !q_fits;
      if (q_fits) begin
        out_q.dot_result <= q_val[VALUE_W-1:0];
      end else begin
        out_q.dot_result <= q_val[Q_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                         : {1'b0, {(VALUE_W-1){1'b1}}};
      end
    end
  end

`ifndef ASSERT_OFF
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s2_valid_q && s2_emit_q) |=> (acc_q == '0 && !ovf_q && s3_valid_q))
    else $error("column close did not clear the accumulator");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} < 17'(MAX_COLUMNS))
    else $error("column counter out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(s3_valid_q) && $stable(acc_q) && $stable(col_q)))
    else $error("back stages moved while output held");
`endif

endmodule

/* hw/rtl/sparse_column_dot_product_top.sv */
// top level of the sparse column dot product block
//
//   port group   dir  word type          handshake
//   in_*         in   scdp_pkg::item_t   in_valid_i / in_stall_o
//   out_*        out  scdp_pkg::result_t out_valid_o / out_stall_i
//
// one input word per cycle while in_stall_o is low; out_valid_o rises once a column's
// closing word has passed the front register, one queue slot and four back stages
// (store read, multiply, accumulate, output conversion)
// reset clears all control state and the accumulator; dense store contents are kept
// an output stall freezes the back stages; the front keeps taking words until the queue fills
module sparse_column_dot_product_top #(
  parameter int VECTOR_DEPTH = scdp_pkg::VECTOR_DEPTH_DEF,
  parameter int MAX_COLUMNS  = scdp_pkg::MAX_COLUMNS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  scdp_pkg::item_t   in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output scdp_pkg::result_t out_word_o
);
  import scdp_pkg::*;

  logic push, full, q_valid, pop;
  cmd_t push_cmd, pop_cmd;

  scdp_front #(
    .VECTOR_DEPTH(VECTOR_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .cmd_valid_o(push),
    .cmd_full_i (full),
    .cmd_o      (push_cmd)
  );

  scdp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (full),
    .valid_o   (q_valid),
    .pop_i     (pop),
    .pop_cmd_o (pop_cmd)
  );

  scdp_back #(
    .VECTOR_DEPTH(VECTOR_DEPTH),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (pop_cmd),
    .cmd_pop_o  (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule
